/* sv/joint_pd_torque_control_assert.svh */
// Assertion macros shared by the joint PD torque controller RTL.
`ifndef JOINT_PD_TORQUE_CONTROL_ASSERT_SVH
`define JOINT_PD_TORQUE_CONTROL_ASSERT_SVH
`ifndef SYNTH
`define JPD_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define JPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JPD_ASSERT_NOW(lbl, cond, msg)
`define JPD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/jpd_pkg.sv */
// Shared types, codes and reset tables of the joint PD torque controller.
`default_nettype none
package jpd_pkg;

  localparam logic [1:0] CMD_STEP = 2'd0;
  localparam logic [1:0] CMD_SEED = 2'd1;
  localparam logic [1:0] CMD_GAIN = 2'd2;

  localparam logic [1:0] CFG_MAX_TARGET_STEP = 2'd0;
  localparam logic [1:0] CFG_FILTER_GAIN     = 2'd1;
  localparam logic [1:0] CFG_MAX_TORQUE_STEP = 2'd2;

  // Shared multiplier: 18-bit signed gain operand by 34-bit signed value.
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 34;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int RESET_JOINTS = 7;
  localparam logic [31:0] KP_RESET [RESET_JOINTS] = '{
    32'd13107200, 32'd13107200, 32'd13107200, 32'd2621440,
    32'd1966080, 32'd1310720, 32'd393216};
  localparam logic [31:0] KD_RESET [RESET_JOINTS] = '{
    32'd1853638, 32'd1853638, 32'd1853638, 32'd828972,
    32'd717911, 32'd586172, 32'd321060};

  typedef struct packed {
    logic        ft_we;
    logic        prev_we;
    logic        gain_we;
    logic [31:0] ft;
    logic [31:0] prev;
    logic [31:0] kp;
    logic [31:0] kd;
  } jpd_wr_t;

  typedef struct packed {
    logic [31:0] ft;
    logic [31:0] prev;
    logic [31:0] kp;
    logic [31:0] kd;
  } jpd_rd_t;

endpackage
`default_nettype wire

/* sv/jpd_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none
module jpd_mul
  import jpd_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] prod
);

  logic signed [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

/* sv/jpd_store.sv */
// Per-joint state: filtered target, previous torque and the kp/kd gain table.
`default_nettype none
module jpd_store
  import jpd_pkg::*;
#(
  parameter int NUM_JOINTS = 7,
  localparam int JIDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [JIDX_W-1:0] idx,
  input  jpd_wr_t           wr,
  output jpd_rd_t           rd
);

  logic [31:0] ft_r   [NUM_JOINTS];
  logic [31:0] prev_r [NUM_JOINTS];
  logic [31:0] kp_r   [NUM_JOINTS];
  logic [31:0] kd_r   [NUM_JOINTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_JOINTS; j++) begin
        ft_r[j]   <= '0;
        prev_r[j] <= '0;
        // Joints past the table take the gains of the last entry.
        kp_r[j]   <= KP_RESET[(j < RESET_JOINTS) ? j : RESET_JOINTS - 1];
        kd_r[j]   <= KD_RESET[(j < RESET_JOINTS) ? j : RESET_JOINTS - 1];
      end
    end else begin
      if (wr.ft_we) begin
        ft_r[idx] <= wr.ft;
      end
      if (wr.prev_we) begin
        prev_r[idx] <= wr.prev;
      end
      if (wr.gain_we) begin
        kp_r[idx] <= wr.kp;
        kd_r[idx] <= wr.kd;
      end
    end
  end

  always_comb begin
    rd.ft   = ft_r[idx];
    rd.prev = prev_r[idx];
    rd.kp   = kp_r[idx];
    rd.kd   = kd_r[idx];
  end

endmodule
`default_nettype wire

/* sv/joint_pd_torque_control.sv */
// Top level of the joint PD torque controller: sequencer and datapath.
//
//   channel  direction  payload                                     handshake
//   in_      slave      tuser: command; tdata: joint, pos, vel,     tvalid/tready
//                       coriolis, target, kp, kd
//   out_     master     tdata: joint, torque                        tvalid/tready
//   cfg_     slave      cfg_index, cfg_data                         valid/ready
//
// A control step is accepted in the idle state, then runs through 17 steps of the sequencer
// around the single 18x34 multiplier (filter move, two partial products for kp,
// two for kd) and the adder that accumulates them and applies the limits.
// Seed, gain-load and ignored items are taken in the idle state.
// The result sits in an output register; if it is still not taken when the next
// one is ready, the sequencer waits in its last step.
// Reset is synchronous; it restores registers, filtered targets, torques and gains.
`default_nettype none
`include "joint_pd_torque_control_assert.svh"
module joint_pd_torque_control
  import jpd_pkg::*;
#(
  parameter int NUM_JOINTS = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // bits from 0: joint[2:0], measured_position[34:3], measured_velocity[66:35],
  // coriolis_torque[98:67], target_position[130:99], stiffness_gain[162:131],
  // damping_gain[194:163], zero fill[199:195]
  input  logic [199:0] in_tdata,
  // bits from 0: command[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // bits from 0: out_joint[2:0], torque[34:3], zero fill[39:35]
  output logic [39:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int JIDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int ACC_W  = 66;
  localparam int TAU_W  = 44;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DIFF = 5'd1;
  localparam logic [4:0] S_CLMP = 5'd2;
  localparam logic [4:0] S_MULF = 5'd3;
  localparam logic [4:0] S_FILT = 5'd4;
  localparam logic [4:0] S_ERR  = 5'd5;
  localparam logic [4:0] S_KPL  = 5'd6;
  localparam logic [4:0] S_KPH  = 5'd7;
  localparam logic [4:0] S_KPA  = 5'd8;
  localparam logic [4:0] S_KDL  = 5'd9;
  localparam logic [4:0] S_KDH  = 5'd10;
  localparam logic [4:0] S_KDA  = 5'd11;
  localparam logic [4:0] S_SUB  = 5'd12;
  localparam logic [4:0] S_COR  = 5'd13;
  localparam logic [4:0] S_SAT  = 5'd14;
  localparam logic [4:0] S_RATE = 5'd15;
  localparam logic [4:0] S_RLIM = 5'd16;
  localparam logic [4:0] S_WOUT = 5'd17;

  localparam logic signed [ACC_W-1:0]   ROUND24 = ACC_W'(64'sd8388608);
  localparam logic signed [MUL_P_W-1:0] ROUND16 = MUL_P_W'(64'sd32768);
  localparam logic signed [TAU_W-1:0]   TAU_MAX = TAU_W'($signed(32'h7FFFFFFF));
  localparam logic signed [TAU_W-1:0]   TAU_MIN = TAU_W'($signed(32'h80000000));

  function automatic logic signed [31:0] clamp_lim(input logic signed [32:0] x,
                                                   input logic [30:0] lim);
    logic signed [32:0] hi;
    logic signed [32:0] r;
    hi = $signed({2'b00, lim});
    if (x > hi) begin
      r = hi;
    end else if (x < -hi) begin
      r = -hi;
    end else begin
      r = x;
    end
    return r[31:0];
  endfunction

  // Input fields.
  logic [1:0]         in_cmd;
  logic [2:0]         in_joint;
  logic signed [31:0] in_pos;
  logic signed [31:0] in_vel;
  logic signed [31:0] in_cor;
  logic signed [31:0] in_tgt;
  logic [31:0]        in_kp;
  logic [31:0]        in_kd;

  assign in_cmd   = in_tuser[1:0];
  assign in_joint = in_tdata[2:0];
  assign in_pos   = $signed(in_tdata[34:3]);
  assign in_vel   = $signed(in_tdata[66:35]);
  assign in_cor   = $signed(in_tdata[98:67]);
  assign in_tgt   = $signed(in_tdata[130:99]);
  assign in_kp    = in_tdata[162:131];
  assign in_kd    = in_tdata[194:163];

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  logic [30:0] mts_r;
  logic [16:0] fgain_r;
  logic [30:0] mtq_r;

  logic [2:0]         j_r;
  logic signed [31:0] pos_r;
  logic signed [31:0] vel_r;
  logic signed [31:0] cor_r;
  logic signed [31:0] tgt_r;
  logic signed [32:0] diff_r;
  logic signed [31:0] d_r;
  logic signed [31:0] ftn_r;
  logic signed [32:0] err_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [TAU_W-1:0] tau_r;
  logic signed [31:0] tsat_r;
  logic signed [32:0] rdiff_r;
  logic signed [31:0] rd_r;

  logic               out_tvalid_r;
  logic [2:0]         out_joint_r;
  logic [31:0]        torque_r;

  logic in_acc;
  logic in_joint_ok;
  logic out_free;
  logic out_load;

  logic [JIDX_W-1:0] st_idx;
  jpd_wr_t           st_wr;
  jpd_rd_t           st_rd;

  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  logic [16:0]               g_sat;
  logic signed [MUL_P_W-1:0] fmove;
  logic signed [31:0]        ft_new;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [31:0]        res;

  assign in_tready   = (state_r == S_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign in_joint_ok = (5'(in_joint) < 5'(NUM_JOINTS));
  assign out_free    = !out_tvalid_r || out_tready;
  assign out_load    = (state_r == S_WOUT) && out_free;
  assign cfg_ready   = 1'b1;

  assign g_sat    = (fgain_r > 17'd65536) ? 17'd65536 : fgain_r;
  assign fmove    = (prod + ROUND16) >>> 16;
  assign ft_new   = $signed(st_rd.ft) + fmove[31:0];
  assign prod_ext = ACC_W'(prod);
  assign res      = $signed(st_rd.prev) + rd_r;

  assign st_idx = (state_r == S_IDLE) ? JIDX_W'(in_joint) : JIDX_W'(j_r);

  always_comb begin
    st_wr.ft_we   = 1'b0;
    st_wr.prev_we = out_load;
    st_wr.gain_we = 1'b0;
    st_wr.ft      = ftn_r;
    st_wr.prev    = res;
    st_wr.kp      = in_kp;
    st_wr.kd      = in_kd;
    if (state_r == S_IDLE) begin
      st_wr.ft      = in_pos;
      st_wr.ft_we   = in_acc && in_joint_ok && (in_cmd == CMD_SEED);
      st_wr.gain_we = in_acc && in_joint_ok && (in_cmd == CMD_GAIN);
    end else if (state_r == S_FILT) begin
      st_wr.ft    = ft_new;
      st_wr.ft_we = 1'b1;
    end
  end

  jpd_store #(
    .NUM_JOINTS(NUM_JOINTS)
  ) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .idx  (st_idx),
    .wr   (st_wr),
    .rd   (st_rd)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_MULF: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, g_sat});
        mul_b  = MUL_B_W'(d_r);
      end
      S_KPL: begin
        mul_en = 1'b1;
        mul_a  = $signed({2'b00, st_rd.kp[15:0]});
        mul_b  = MUL_B_W'(err_r);
      end
      S_KPH: begin
        mul_en = 1'b1;
        mul_a  = $signed({2'b00, st_rd.kp[31:16]});
        mul_b  = MUL_B_W'(err_r);
      end
      S_KDL: begin
        mul_en = 1'b1;
        mul_a  = $signed({2'b00, st_rd.kd[15:0]});
        mul_b  = MUL_B_W'(vel_r);
      end
      S_KDH: begin
        mul_en = 1'b1;
        mul_a  = $signed({2'b00, st_rd.kd[31:16]});
        mul_b  = MUL_B_W'(vel_r);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  jpd_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_joint_ok && (in_cmd == CMD_STEP)) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: state_nxt = S_CLMP;
      S_CLMP: state_nxt = S_MULF;
      S_MULF: state_nxt = S_FILT;
      S_FILT: state_nxt = S_ERR;
      S_ERR:  state_nxt = S_KPL;
      S_KPL:  state_nxt = S_KPH;
      S_KPH:  state_nxt = S_KPA;
      S_KPA:  state_nxt = S_KDL;
      S_KDL:  state_nxt = S_KDH;
      S_KDH:  state_nxt = S_KDA;
      S_KDA:  state_nxt = S_SUB;
      S_SUB:  state_nxt = S_COR;
      S_COR:  state_nxt = S_SAT;
      S_SAT:  state_nxt = S_RATE;
      S_RATE: state_nxt = S_RLIM;
      S_RLIM: state_nxt = S_WOUT;
      S_WOUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      mts_r        <= 31'h7FFFFFFF;
      fgain_r      <= 17'd65536;
      mtq_r        <= 31'd65536;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_TARGET_STEP: mts_r   <= cfg_data[30:0];
          CFG_FILTER_GAIN:     fgain_r <= cfg_data[16:0];
          CFG_MAX_TORQUE_STEP: mtq_r   <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      j_r   <= in_joint;
      pos_r <= in_pos;
      vel_r <= in_vel;
      cor_r <= in_cor;
      tgt_r <= in_tgt;
    end
    case (state_r)
      S_DIFF: diff_r  <= 33'(tgt_r) - 33'($signed(st_rd.ft));
      S_CLMP: d_r     <= clamp_lim(diff_r, mts_r);
      S_FILT: ftn_r   <= ft_new;
      S_ERR:  err_r   <= 33'(ftn_r) - 33'(pos_r);
      S_KPH:  acc_r   <= prod_ext + ROUND24;
      S_KPA:  acc_r   <= acc_r + (prod_ext <<< 16);
      S_KDL:  tau_r   <= TAU_W'(acc_r >>> 24);
      S_KDH:  acc_r   <= prod_ext + ROUND24;
      S_KDA:  acc_r   <= acc_r + (prod_ext <<< 16);
      S_SUB:  tau_r   <= tau_r - TAU_W'(acc_r >>> 24);
      S_COR:  tau_r   <= tau_r + TAU_W'(cor_r);
      S_SAT: begin
        if (tau_r > TAU_MAX) begin
          tsat_r <= TAU_MAX[31:0];
        end else if (tau_r < TAU_MIN) begin
          tsat_r <= TAU_MIN[31:0];
        end else begin
          tsat_r <= tau_r[31:0];
        end
      end
      S_RATE: rdiff_r <= 33'(tsat_r) - 33'($signed(st_rd.prev));
      S_RLIM: rd_r    <= clamp_lim(rdiff_r, mtq_r);
      default: ;
    endcase
    if (out_load) begin
      out_joint_r <= j_r;
      torque_r    <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b00000, torque_r, out_joint_r};

  `JPD_ASSERT_NEXT(a_step_starts, in_acc && in_joint_ok && (in_cmd == CMD_STEP), state_r == S_DIFF, "control step did not start")
  `JPD_ASSERT_NOW(a_filter_bounded, (state_r != S_FILT) || ((d_r >= 32'sd0) ? (fmove >= 0 && fmove <= MUL_P_W'(d_r)) : (fmove <= 0 && fmove >= MUL_P_W'(d_r))), "filter move overshoots the clamped step")
  `JPD_ASSERT_NOW(a_torque_rate, !out_load || (rd_r <= $signed({1'b0, mtq_r}) && rd_r >= -$signed({1'b0, mtq_r})), "torque change exceeds its limit")
  `JPD_ASSERT_NEXT(a_result_loaded, out_load, out_tvalid_r && (state_r == S_IDLE), "finished result not presented")

endmodule
`default_nettype wire

/* dv/joint_pd_torque_control_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the joint PD torque controller: directed and random streams.
module joint_pd_torque_control_tb;
  import jpd_pkg::*;

  localparam int JOINTS = 7;
  localparam logic [1:0] CMD_UNUSED = 2'd3;  // no such command, the block drops it
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 305;
  localparam longint TORQUE_MAX = 64'sd2147483647;
  localparam longint TORQUE_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  joint;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] cor;
    logic [31:0] tgt;
    logic [31:0] kp;
    logic [31:0] kd;
  } joint_item_t;

  typedef struct packed {
    logic [2:0]  joint;
    logic [31:0] torque;
  } torque_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [199:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [39:0]  out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  joint_pd_torque_control dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Local copy of the controller state and registers.
  logic [31:0] ft_mem [JOINTS];
  logic [31:0] prev_mem [JOINTS];
  logic [31:0] kp_mem [JOINTS];
  logic [31:0] kd_mem [JOINTS];
  logic [30:0] lim_target;
  logic [16:0] filt_gain;
  logic [30:0] lim_torque;

  joint_item_t pending [$];
  torque_res_t torque_q [$];
  joint_item_t cur;
  int          n_queued = 0;
  int          n_accepted = 0;
  int          mismatches = 0;
  logic        in_done = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  logic        quiet = 1'b0;

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic longint clamp_mag(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // round(g * x / 2^24), half up; the full product needs more than 64 bits.
  function automatic longint scale_by_gain(input logic [31:0] g, input longint x);
    logic signed [127:0] p;
    p = $signed({1'b0, g}) * x;
    p = p + 128'sd8388608;
    p = p >>> 24;
    return longint'(p);
  endfunction

  task automatic predict_torque(input joint_item_t it);
    longint ft, d, g, tau, prev, res;
    torque_res_t r;
    if (it.joint >= JOINTS) return;
    case (it.cmd)
      CMD_SEED: ft_mem[it.joint] = it.pos;
      CMD_GAIN: begin
        kp_mem[it.joint] = it.kp;
        kd_mem[it.joint] = it.kd;
      end
      CMD_STEP: begin
        ft = longint'($signed(ft_mem[it.joint]));
        d = clamp_mag(longint'($signed(it.tgt)) - ft, longint'(lim_target));
        g = (filt_gain > 17'd65536) ? 64'sd65536 : longint'(filt_gain);
        ft = ft + ((g * d + 64'sd32768) >>> 16);
        ft_mem[it.joint] = ft[31:0];
        tau = scale_by_gain(kp_mem[it.joint], ft - longint'($signed(it.pos)))
              - scale_by_gain(kd_mem[it.joint], longint'($signed(it.vel)))
              + longint'($signed(it.cor));
        if (tau > TORQUE_MAX) tau = TORQUE_MAX;
        if (tau < TORQUE_MIN) tau = TORQUE_MIN;
        prev = longint'($signed(prev_mem[it.joint]));
        res = prev + clamp_mag(tau - prev, longint'(lim_torque));
        prev_mem[it.joint] = res[31:0];
        r.joint = it.joint;
        r.torque = res[31:0];
        torque_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap(input logic steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_stall(input logic steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 85) return 0;
    if (r < 97) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Mostly plausible magnitudes, with full-range words and extremes mixed in.
  function automatic logic [31:0] any_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom();
    if (r < 9) return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] any_gain();
    if ($urandom_range(0, 9) < 6) return $urandom_range(0, 32'h0100_0000);
    return $urandom();
  endfunction

  function automatic joint_item_t make_item(input logic [1:0] cmd, input logic [2:0] joint,
                                            input logic [31:0] pos, input logic [31:0] vel,
                                            input logic [31:0] cor, input logic [31:0] tgt,
                                            input logic [31:0] kp, input logic [31:0] kd);
    joint_item_t it;
    it.cmd = cmd;
    it.joint = joint;
    it.pos = pos;
    it.vel = vel;
    it.cor = cor;
    it.tgt = tgt;
    it.kp = kp;
    it.kd = kd;
    return it;
  endfunction

  task automatic send(input joint_item_t it);
    pending.push_back(it);
    n_queued++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MAX_TARGET_STEP: lim_target = val[30:0];
      CFG_FILTER_GAIN:     filt_gain = val[16:0];
      CFG_MAX_TORQUE_STEP: lim_torque = val[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every item is taken and every torque has come back, then let the
  // sequencer finish whatever it still holds before registers may change.
  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    while ((n_accepted != n_queued || torque_q.size() != 0) && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      report($sformatf("%0d torque results never arrived", torque_q.size()));
      torque_q.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_batch(input int count);
    int made, r;
    joint_item_t it;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      it = make_item(CMD_STEP, 3'($urandom_range(0, JOINTS - 1)), any_word(), any_word(),
                     any_word(), any_word(), any_gain(), any_gain());
      if (r < 70) it.cmd = CMD_STEP;
      else if (r < 80) it.cmd = CMD_SEED;
      else if (r < 88) it.cmd = CMD_GAIN;
      else if ($urandom_range(0, 1) == 0) it.cmd = CMD_UNUSED;
      else begin
        it.joint = 3'd7;
        it.cmd = 2'($urandom_range(0, 3));
      end
      send(it);
      made++;
    end
  endtask

  // Sender: one item per transfer, random gaps after each transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_done) begin
      in_tvalid <= 1'b1;
    end else if (send_gap > 0) begin
      in_tvalid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending.size() != 0) begin
      cur = pending.pop_front();
      in_tvalid <= 1'b1;
      in_tuser <= cur.cmd;
      in_tdata <= {5'd0, cur.kd, cur.kp, cur.tgt, cur.cor, cur.vel, cur.pos, cur.joint};
      send_gap <= pick_gap(quiet);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_stall(quiet);
    end
  end

  always @(posedge clk) begin : monitor
    torque_res_t want;
    in_done <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_torque(cur);
        n_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (torque_q.size() == 0) begin
          report($sformatf("unexpected torque %0d for joint %0d",
                           $signed(out_tdata[34:3]), out_tdata[2:0]));
        end else begin
          want = torque_q.pop_front();
          if (out_tdata[2:0] != want.joint)
            report($sformatf("joint %0d, expected %0d", out_tdata[2:0], want.joint));
          if (out_tdata[34:3] != want.torque)
            report($sformatf("joint %0d torque %0d, expected %0d", want.joint,
                             $signed(out_tdata[34:3]), $signed(want.torque)));
        end
      end
    end
  end

  initial begin
    for (int j = 0; j < JOINTS; j++) begin
      ft_mem[j] = '0;
      prev_mem[j] = '0;
    end
    kp_mem = '{32'd13107200, 32'd13107200, 32'd13107200, 32'd2621440,
               32'd1966080, 32'd1310720, 32'd393216};
    kd_mem = '{32'd1853638, 32'd1853638, 32'd1853638, 32'd828972,
               32'd717911, 32'd586172, 32'd321060};
    lim_target = 31'h7FFF_FFFF;
    filt_gain = 17'd65536;
    lim_torque = 31'd65536;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset register values.
    send(make_item(CMD_STEP, 3'd0, '0, '0, '0, '0, '0, '0));
    send(make_item(CMD_STEP, 3'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, '0, '0));
    send(make_item(CMD_STEP, 3'd6, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, '0, '0));
    send(make_item(CMD_SEED, 3'd2, 32'h7FFF_FFFF, '0, '0, '0, '0, '0));
    send(make_item(CMD_STEP, 3'd2, 32'h0100_0000, 32'h0080_0000, 32'h0001_0000,
                   32'h8000_0000, '0, '0));
    send(make_item(CMD_STEP, 3'd7, '1, '1, '1, '1, '1, '1));
    send(make_item(CMD_UNUSED, 3'd3, '1, '1, '1, '1, '1, '1));
    send(make_item(CMD_GAIN, 3'd7, '0, '0, '0, '0, 32'h0001_0000, 32'h0001_0000));
    for (int j = 3; j < 6; j++)
      send(make_item(CMD_STEP, 3'(j), any_word(), any_word(), any_word(), any_word(),
                     '0, '0));
    drain();

    // Extremes of gains and sums with the torque rate limit wide open.
    write_reg(CFG_MAX_TORQUE_STEP, 32'h7FFF_FFFF);
    send(make_item(CMD_GAIN, 3'd4, '0, '0, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(make_item(CMD_STEP, 3'd4, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, '0, '0));
    send(make_item(CMD_STEP, 3'd4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, '0, '0));
    send(make_item(CMD_GAIN, 3'd5, '0, '0, '0, '0, '0, '0));
    send(make_item(CMD_STEP, 3'd5, any_word(), any_word(), 32'hFFF0_0000, any_word(),
                   '0, '0));
    send(make_item(CMD_SEED, 3'd0, 32'h8000_0000, '0, '0, '0, '0, '0));
    send(make_item(CMD_STEP, 3'd0, 32'h8000_0000, '0, '0, 32'h7FFF_FFFF, '0, '0));
    for (int j = 0; j < JOINTS; j++)
      send(make_item(CMD_STEP, 3'(j), any_word(), any_word(), any_word(), any_word(),
                     '0, '0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      quiet = (ph == 0 || ph == 4);
      case (ph)
        0: begin
          write_reg(CFG_MAX_TARGET_STEP, 32'h7FFF_FFFF);
          write_reg(CFG_FILTER_GAIN, 32'd65536);
          write_reg(CFG_MAX_TORQUE_STEP, 32'h7FFF_FFFF);
        end
        1: begin
          write_reg(CFG_MAX_TARGET_STEP, 32'd0);
          write_reg(CFG_FILTER_GAIN, 32'd131071);
          write_reg(CFG_MAX_TORQUE_STEP, 32'd0);
        end
        2: begin
          write_reg(CFG_MAX_TARGET_STEP, $urandom_range(0, 32'h0100_0000));
          write_reg(CFG_FILTER_GAIN, $urandom_range(0, 65536));
          write_reg(CFG_MAX_TORQUE_STEP, $urandom_range(32'h1000, 32'h0040_0000));
        end
        3: begin
          write_reg(CFG_MAX_TARGET_STEP, $urandom());
          write_reg(CFG_FILTER_GAIN, $urandom());
          write_reg(CFG_MAX_TORQUE_STEP, $urandom());
        end
        4: begin
          write_reg(CFG_MAX_TARGET_STEP, $urandom_range(0, 32'h0400_0000));
          write_reg(CFG_FILTER_GAIN, $urandom_range(0, 65536));
          write_reg(CFG_MAX_TORQUE_STEP, 32'h7FFF_FFFF);
        end
        default: begin
          write_reg(CFG_MAX_TARGET_STEP, 32'd1);
          write_reg(CFG_FILTER_GAIN, 32'd0);
          write_reg(CFG_MAX_TORQUE_STEP, 32'd1);
        end
      endcase
      random_batch(PHASE_ITEMS);
      // Hold the result side off while the sender keeps offering items.
      if (ph == 4) hold_req = ~hold_req;
      drain();
    end

    if (mismatches == 0) begin
      $display("joint_pd_torque_control: match");
    end else begin
      $display("joint_pd_torque_control: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("ERROR: run timed out");
    $display("joint_pd_torque_control: mismatch");
    $finish;
  end

endmodule
